>>> rtl/core/fifo_queue_with_delete_assert.svh
// Assertion macros for the tag queue with delete.
// Included by fifo_queue_with_delete.sv; relies on no other file.
`ifndef FIFO_QUEUE_WITH_DELETE_ASSERT_SVH
`define FIFO_QUEUE_WITH_DELETE_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define FQD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fqd: invariant violated");

// Consequence in the same cycle.
`define FQD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqd: same-cycle implication violated");

// Consequence in the next cycle.
`define FQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqd: next-cycle implication violated");

`endif

>>> rtl/core/fqd_pkg.sv
// Shared constants for the tag queue with delete: default sizes,
// operation codes and status codes. No dependencies.
package fqd_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 32;
    localparam int CNT_W_DEF    = $clog2(DEPTH_DEF + 1);

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

endpackage

>>> rtl/core/fqd_req_if.sv
// Request channel of the tag queue: valid/ready plus operation and tag.
// Depends on fqd_pkg for widths.
interface fqd_req_if #(
    parameter int TAG_BITS = fqd_pkg::TAG_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [fqd_pkg::MODE_W-1:0]  mode;
    logic [TAG_BITS-1:0]         tag;

    modport source (output valid, output mode, output tag, input ready);
    modport sink   (input valid, input mode, input tag, output ready);
endinterface

>>> rtl/core/fqd_rsp_if.sv
// Response channel of the tag queue: valid/ready plus status, tag and fill.
// Depends on fqd_pkg for widths.
interface fqd_rsp_if #(
    parameter int TAG_BITS = fqd_pkg::TAG_BITS_DEF,
    parameter int CNT_W    = fqd_pkg::CNT_W_DEF
);
    logic                          valid;
    logic                          ready;
    logic [fqd_pkg::STATUS_W-1:0]  status;
    logic [TAG_BITS-1:0]           tag_out;
    logic [CNT_W-1:0]              fill;

    modport source (output valid, output status, output tag_out, output fill, input ready);
    modport sink   (input valid, input status, input tag_out, input fill, output ready);
endinterface

>>> rtl/core/fifo_queue_with_delete.sv
// Bounded queue of nonzero tags with enqueue, dequeue and delete-by-value.
// The tags live in a single circular buffer memory (one write port, one
// read port, registered read data) addressed from a head pointer. Every
// request yields one response. Enqueue and any request answered from the
// fill count alone (null tag, full, empty, unused mode, delete on an empty
// queue) are answered straight from the idle state; dequeue passes
// through ST_DEQ for its memory read. Delete streams the buffer from the
// oldest entry, one entry per cycle through the read port, then moves
// the younger entries down one place while the next one is being read.
// The response sits in an output register, so a new request is taken as
// soon as the block is idle and that register is empty or being drained.
// No clearing pass after reset: only entries below the fill are ever
// used, though a delete may read one position past it.
// Depends on fqd_pkg, fqd_req_if, fqd_rsp_if and the assertion macros.
`include "fifo_queue_with_delete_assert.svh"

module fifo_queue_with_delete #(
    parameter int DEPTH    = fqd_pkg::DEPTH_DEF,
    parameter int TAG_BITS = fqd_pkg::TAG_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fqd_req_if.sink    req,
    fqd_rsp_if.source  rsp
);
    import fqd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW:0]   WRAP     = (AW + 1)'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DEQ   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_SHIFT = 4'b1000
    } state_t;

    // queue position to buffer address
    function automatic logic [AW-1:0] pos_addr(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= WRAP)
            sum = sum - WRAP;
        return sum[AW-1:0];
    endfunction

    logic [TAG_BITS-1:0] mem [DEPTH];
    logic [TAG_BITS-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [TAG_BITS-1:0]  key_reg, key_next;
    logic                 ov_reg, ov_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [TAG_BITS-1:0]  tag_out_reg, tag_out_next;
    logic [CW-1:0]        fill_reg, fill_next;

    logic                 accept;
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [TAG_BITS-1:0]  wr_data;
    logic [CW-1:0]        pos_inc, pos_dec;
    logic                 load_out;
    logic [STATUS_W-1:0]  ld_status;
    logic [TAG_BITS-1:0]  ld_tag;
    logic [CW-1:0]        ld_fill;
    logic                 deq_on_empty;

    assign req.ready   = (state_reg == ST_IDLE) && (!ov_reg || rsp.ready);
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = ov_reg;
    assign rsp.status  = status_reg;
    assign rsp.tag_out = tag_out_reg;
    assign rsp.fill    = fill_reg;

    assign pos_inc = pos_reg + CW'(1);
    assign pos_dec = pos_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = rd_data_reg;
        load_out   = 1'b0;
        ld_status  = STAT_OK;
        ld_tag     = '0;
        ld_fill    = count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_ENQ:
                        begin
                            load_out = 1'b1;
                            if (req.tag == '0)
                                ld_status = STAT_NULL;
                            else if (count_reg == FULL_CNT)
                                ld_status = STAT_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = pos_addr(head_reg, count_reg[AW-1:0]);
                                wr_data    = req.tag;
                                count_next = count_reg + CW'(1);
                                ld_fill    = count_reg + CW'(1);
                            end
                        end
                        MODE_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out  = 1'b1;
                                ld_status = STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = ST_DEQ;
                            end
                        end
                        MODE_DEL:
                        begin
                            if (req.tag == '0)
                            begin
                                load_out  = 1'b1;
                                ld_status = STAT_NULL;
                            end
                            else if (count_reg == '0)
                            begin
                                load_out  = 1'b1;
                                ld_status = STAT_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                key_next   = req.tag;
                                pos_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                load_out   = 1'b1;
                ld_tag     = rd_data_reg;
                ld_fill    = count_reg - CW'(1);
                count_next = count_reg - CW'(1);
                head_next  = pos_addr(head_reg, AW'(1));
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // read ahead one position while comparing the current one
                rd_en   = 1'b1;
                rd_addr = pos_addr(head_reg, pos_inc[AW-1:0]);
                if (rd_data_reg == key_reg)
                begin
                    pos_next   = pos_inc;
                    state_next = ST_SHIFT;
                end
                else if (pos_inc == count_reg)
                begin
                    load_out   = 1'b1;
                    ld_status  = STAT_NOTFOUND;
                    state_next = ST_IDLE;
                end
                else
                    pos_next = pos_inc;
            end
            ST_SHIFT:
            begin
                if (pos_reg < count_reg)
                begin
                    // drop entry at pos into the slot below, fetch the next
                    wr_en    = 1'b1;
                    wr_addr  = pos_addr(head_reg, pos_dec[AW-1:0]);
                    wr_data  = rd_data_reg;
                    rd_en    = 1'b1;
                    rd_addr  = pos_addr(head_reg, pos_inc[AW-1:0]);
                    pos_next = pos_inc;
                end
                else
                begin
                    load_out   = 1'b1;
                    ld_fill    = count_reg - CW'(1);
                    count_next = count_reg - CW'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ov_next      = ov_reg && !rsp.ready;
        status_next  = status_reg;
        tag_out_next = tag_out_reg;
        fill_next    = fill_reg;
        if (load_out)
        begin
            ov_next      = 1'b1;
            status_next  = ld_status;
            tag_out_next = ld_tag;
            fill_next    = ld_fill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        tag_out_reg <= tag_out_next;
        fill_reg    <= fill_next;
    end

    assign deq_on_empty = accept && (req.mode == MODE_DEQ) && (count_reg == '0);

    `FQD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_CNT)
    `FQD_ASSERT_IMPLY(a_busy_no_rsp, clk, rst_n, state_reg != ST_IDLE, !ov_reg)
    `FQD_ASSERT_NEXT(a_deq_empty, clk, rst_n, deq_on_empty, ov_reg && status_reg == STAT_EMPTY)

endmodule

>>> tb/fifo_queue_with_delete_check.sv
// Checker for the tag queue with delete: watches the request and response
// channels, keeps its own copy of the queue and compares every response.
// Depends on fqd_pkg, fqd_req_if and fqd_rsp_if.
module fifo_queue_with_delete_check (
    input  logic      clk,
    input  logic      rst_n,
    fqd_req_if        req,
    fqd_rsp_if        rsp,
    output int        fail_count,
    output int        outstanding,
    output int        checked_count,
    output int        peak_fill
);
    import fqd_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [TAG_BITS_DEF-1:0] tag_out;
        logic [CNT_W_DEF-1:0]    fill;
    } queue_rsp_t;

    logic [TAG_BITS_DEF-1:0] held_tags[$];
    queue_rsp_t              rsp_expected[$];
    queue_rsp_t              want;
    int                      errors;
    int                      waiting;
    int                      checked;
    int                      fill_max;

    assign fail_count    = errors;
    assign outstanding   = waiting;
    assign checked_count = checked;
    assign peak_fill     = fill_max;

    initial
    begin
        errors   = 0;
        waiting  = 0;
        checked  = 0;
        fill_max = 0;
    end

    // Apply one request to the shadow queue and return its response.
    function automatic queue_rsp_t apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic [TAG_BITS_DEF-1:0] tag);
        queue_rsp_t r;
        int         hit_pos;
        r.status  = STAT_OK;
        r.tag_out = '0;
        hit_pos   = -1;
        case (mode)
            MODE_ENQ:
            begin
                if (tag == '0)
                    r.status = STAT_NULL;
                else if (held_tags.size() >= DEPTH_DEF)
                    r.status = STAT_FULL;
                else
                    held_tags.push_back(tag);
            end
            MODE_DEQ:
            begin
                if (held_tags.size() == 0)
                    r.status = STAT_EMPTY;
                else
                    r.tag_out = held_tags.pop_front();
            end
            MODE_DEL:
            begin
                if (tag == '0)
                    r.status = STAT_NULL;
                else
                begin
                    // search from the oldest entry, first match wins
                    for (int i = 0; i < held_tags.size(); i++)
                    begin
                        if (hit_pos < 0 && held_tags[i] == tag)
                            hit_pos = i;
                    end
                    if (hit_pos < 0)
                        r.status = STAT_NOTFOUND;
                    else
                        held_tags.delete(hit_pos);
                end
            end
            default: ;
        endcase
        r.fill = CNT_W_DEF'(held_tags.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("[%0t] response %0d: %s got 0x%0h, want 0x%0h",
                 $realtime, checked, what, got, exp_val);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_tags.delete();
            rsp_expected.delete();
            waiting = 0;
        end
        else
        begin
            // retire the response first: it can never belong to a request
            // taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_expected.size() == 0)
                    report_mismatch("unexpected response, status", 64'(rsp.status), 64'(0));
                else
                begin
                    want = rsp_expected.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.tag_out !== want.tag_out)
                        report_mismatch("tag_out", 64'(rsp.tag_out), 64'(want.tag_out));
                    if (rsp.fill !== want.fill)
                        report_mismatch("fill", 64'(rsp.fill), 64'(want.fill));
                end
                checked++;
            end
            if (req.valid && req.ready)
            begin
                rsp_expected.push_back(apply_request(req.mode, req.tag));
                if (held_tags.size() > fill_max)
                    fill_max = held_tags.size();
            end
            waiting = rsp_expected.size();
        end
    end
endmodule

>>> tb/fifo_queue_with_delete_test.sv
// Top of the tag queue testbench: clock, reset, request stimulus and
// response back-pressure, with the checker beside the block.
// Depends on fqd_pkg, both channel interfaces and the checker module.
module fifo_queue_with_delete_test;
    import fqd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 166;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   requests_sent;
    int   stall_left;
    int   fail_count;
    int   outstanding;
    int   checked_count;
    int   peak_fill;
    logic [TAG_BITS_DEF-1:0] tag_pool [8];

    fqd_req_if req_ch ();
    fqd_rsp_if rsp_ch ();

    fifo_queue_with_delete i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fifo_queue_with_delete_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .peak_fill     (peak_fill)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("run timed out with %0d responses outstanding", outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hold a request until the block takes it; idle first now and then.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [TAG_BITS_DEF-1:0] tag);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.tag   <= tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic logic [MODE_W-1:0] pick_mode(input int enq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return MODE_UNUSED;
        else if (r < 3 + enq_pct)
            return MODE_ENQ;
        else if (r[0])
            return MODE_DEQ;
        else
            return MODE_DEL;
    endfunction

    // Mostly reuse a small pool so deletes hit and duplicates occur.
    function automatic logic [TAG_BITS_DEF-1:0] pick_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 70)
            return tag_pool[$urandom_range(0, 7)];
        else
            return $urandom;
    endfunction

    // Response back-pressure: random stall bursts while idling is on.
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 16) - 1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int enq_pct;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= MODE_ENQ;
        req_ch.tag    <= '0;
        rsp_ch.ready  <= 1'b0;
        idle_on       = 1'b1;
        requests_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue cases, null tags, unused mode
        send_request(MODE_DEQ, 32'hFFFF_FFFF);
        send_request(MODE_DEL, 32'h0000_0005);
        send_request(MODE_DEL, 32'h0000_0000);
        send_request(MODE_ENQ, 32'h0000_0000);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF);
        // fill to the top, with a duplicate tag
        send_request(MODE_ENQ, 32'hFFFF_FFFF);
        send_request(MODE_ENQ, 32'h0000_0001);
        send_request(MODE_ENQ, 32'h8000_0000);
        send_request(MODE_ENQ, 32'h0000_0007);
        send_request(MODE_ENQ, 32'h0000_0007);
        for (int i = 0; i < DEPTH_DEF - 5; i++)
            send_request(MODE_ENQ, 32'h0000_0100 + i);
        // full queue: null is reported before fullness
        send_request(MODE_ENQ, 32'h0000_0009);
        send_request(MODE_ENQ, 32'h0000_0000);
        // delete first of two matches, the oldest entry, and a miss
        send_request(MODE_DEL, 32'h0000_0007);
        send_request(MODE_DEL, 32'hFFFF_FFFF);
        send_request(MODE_DEL, 32'h0001_2345);
        send_request(MODE_DEQ, 32'h0000_0000);

        // random phases, alternating fill-up and drain bias
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_on = (p != 2) && (p < NUM_PHASES - 2);
            enq_pct = p[0] ? 30 : 65;
            for (int k = 0; k < 8; k++)
                tag_pool[k] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_mode(enq_pct), pick_tag());
        end
        req_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d requests (directed edge cases plus %0d random phases)",
                 requests_sent, NUM_PHASES);
        $display("checked %0d responses, peak fill %0d of %0d",
                 checked_count, peak_fill, DEPTH_DEF);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/fqd_pkg.sv
rtl/core/fqd_req_if.sv
rtl/core/fqd_rsp_if.sv
rtl/core/fifo_queue_with_delete.sv
tb/fifo_queue_with_delete_check.sv
tb/fifo_queue_with_delete_test.sv
